// ===== rtl/core/bdhd_pkg.sv =====
// ----------------------------------------------------------------------------
// bdhd_pkg
// shared widths, codes, reset values and types for the button qualifier
// ----------------------------------------------------------------------------
`default_nettype none

package bdhd_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int CFG_W       = 16;
    localparam int ELAPSED_W   = 8;
    localparam int STATE_W     = 2;
    localparam int CMP_W       = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;
    localparam int REG_IDX_W   = APB_ADDR_W - 2;

    localparam logic [STATE_W-1:0] BTN_OFF  = 2'd0;
    localparam logic [STATE_W-1:0] BTN_ON   = 2'd1;
    localparam logic [STATE_W-1:0] BTN_HELD = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_HOLD     = 1'd1;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd150;
    localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd1000;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ms;
        logic [CFG_W-1:0] hold_ms;
    } t_cfg;

    typedef struct packed {
        logic [STATE_W-1:0] button_state;
        logic               press_event;
        logic               hold_event;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/button_debounce_hold_detect.sv =====
// ----------------------------------------------------------------------------
// button_debounce_hold_detect
// push button qualifier with debounce and long-press detection
// ----------------------------------------------------------------------------
// path: accepted item goes to the input register, then its result to the result register
// throughput: 1 item per cycle while the result channel is not stalled; one timer add and compare between registers
// reset: synchronous active low; mode off, timer zero, limits 150 and 1000 ms
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_hold_detect (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [bdhd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [bdhd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [bdhd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_pressed,
    input  wire logic [bdhd_pkg::ELAPSED_W-1:0]    i_elapsed_ms,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [bdhd_pkg::STATE_W-1:0]      o_button_state,
    output logic                                   o_press_event,
    output logic                                   o_hold_event
);

    bdhd_pkg::t_cfg    w_cfg;
    bdhd_pkg::t_result w_result;

    bdhd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    bdhd_qual u_qual (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pressed    (i_pressed),
        .i_elapsed_ms (i_elapsed_ms),
        .i_cfg        (w_cfg),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (w_result)
    );

    assign o_button_state = w_result.button_state;
    assign o_press_event  = w_result.press_event;
    assign o_hold_event   = w_result.hold_event;

    a_events_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_press_event && o_hold_event))
        else $error("press and hold event in the same item");

    a_press_gives_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_press_event) |-> (o_button_state == bdhd_pkg::BTN_ON))
        else $error("press event without on state");

    a_hold_gives_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_hold_event) |-> (o_button_state == bdhd_pkg::BTN_HELD))
        else $error("hold event without held state");

    a_no_unused_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_button_state == bdhd_pkg::BTN_OFF ||
                         o_button_state == bdhd_pkg::BTN_ON ||
                         o_button_state == bdhd_pkg::BTN_HELD))
        else $error("unused button state code");

endmodule

`default_nettype wire

// ===== rtl/core/bdhd_cfg.sv =====
// ----------------------------------------------------------------------------
// bdhd_cfg
// apb register file holding the debounce and hold limits
// ----------------------------------------------------------------------------
`default_nettype none

module bdhd_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [bdhd_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [bdhd_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [bdhd_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready,
    output bdhd_pkg::t_cfg                          o_cfg
);

    logic [bdhd_pkg::CFG_W-1:0]     r_debounce_ms;
    logic [bdhd_pkg::CFG_W-1:0]     r_hold_ms;
    logic [bdhd_pkg::REG_IDX_W-1:0] w_idx;
    logic                           w_wr;

    assign w_idx  = paddr[bdhd_pkg::APB_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= bdhd_pkg::DEBOUNCE_RESET;
            r_hold_ms     <= bdhd_pkg::HOLD_RESET;
        end else if (w_wr) begin
            case (w_idx)
                bdhd_pkg::REG_DEBOUNCE: r_debounce_ms <= pwdata[bdhd_pkg::CFG_W-1:0];
                bdhd_pkg::REG_HOLD:     r_hold_ms     <= pwdata[bdhd_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            bdhd_pkg::REG_DEBOUNCE: prdata = bdhd_pkg::APB_DATA_W'(r_debounce_ms);
            bdhd_pkg::REG_HOLD:     prdata = bdhd_pkg::APB_DATA_W'(r_hold_ms);
            default:                prdata = '0;
        endcase
    end

    assign o_cfg.debounce_ms = r_debounce_ms;
    assign o_cfg.hold_ms     = r_hold_ms;

endmodule

`default_nettype wire

// ===== rtl/core/bdhd_qual.sv =====
// ----------------------------------------------------------------------------
// bdhd_qual
// input register, saturating timer, off/on/held machine and result register
// ----------------------------------------------------------------------------
`default_nettype none

module bdhd_qual (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_pressed,
    input  wire logic [bdhd_pkg::ELAPSED_W-1:0]    i_elapsed_ms,
    input  wire bdhd_pkg::t_cfg                    i_cfg,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output bdhd_pkg::t_result                      o_result
);

    localparam int TW = bdhd_pkg::TIMER_WIDTH;

    typedef enum logic [bdhd_pkg::STATE_W-1:0] {
        S_OFF  = bdhd_pkg::BTN_OFF,
        S_ON   = bdhd_pkg::BTN_ON,
        S_HELD = bdhd_pkg::BTN_HELD
    } t_mode;

    logic                           r_in_valid;
    logic                           r_pressed;
    logic [bdhd_pkg::ELAPSED_W-1:0] r_elapsed;
    logic                           r_out_valid;
    bdhd_pkg::t_result              r_out;
    t_mode                          r_mode;
    logic [TW-1:0]                  r_timer;

    t_mode                          n_mode;
    logic [TW-1:0]                  n_timer;
    bdhd_pkg::t_result              n_out;

    logic                           w_adv;
    logic [TW:0]                    w_sum;
    logic [TW-1:0]                  w_timer_sat;
    logic                           w_over_deb;
    logic                           w_over_hold;

    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    // saturating timer update
    assign w_sum       = (TW + 1)'(r_timer) + (TW + 1)'(r_elapsed);
    assign w_timer_sat = w_sum[TW] ? {TW{1'b1}} : w_sum[TW-1:0];
    assign w_over_deb  = bdhd_pkg::CMP_W'(w_timer_sat) > bdhd_pkg::CMP_W'(i_cfg.debounce_ms);
    assign w_over_hold = bdhd_pkg::CMP_W'(w_timer_sat) > bdhd_pkg::CMP_W'(i_cfg.hold_ms);

    always_comb begin
        n_mode            = S_OFF;
        n_timer           = w_timer_sat;
        n_out.press_event = 1'b0;
        n_out.hold_event  = 1'b0;
        case (r_mode)
            S_ON, S_HELD: begin
                if (!r_pressed) begin
                    n_mode  = S_OFF;
                    n_timer = '0;
                end else if (r_mode == S_ON && w_over_hold) begin
                    n_mode           = S_HELD;
                    n_out.hold_event = 1'b1;
                end else begin
                    n_mode = r_mode;
                end
            end
            default: begin
                if (r_pressed && w_over_deb) begin
                    n_mode            = S_ON;
                    n_timer           = '0;
                    n_out.press_event = 1'b1;
                end
            end
        endcase
        n_out.button_state = n_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= S_OFF;
            r_timer     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_mode      <= n_mode;
                r_timer     <= n_timer;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_in_ready && i_in_valid) begin
            r_pressed <= i_pressed;
            r_elapsed <= i_elapsed_ms;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

`default_nettype wire

// ===== sim/button_result_checker.sv =====
// ----------------------------------------------------------------------------
// button_result_checker
// watches the sample and result channels and the register port, predicts each
// result of the button qualifier and compares it with the one the block gives
// ----------------------------------------------------------------------------
module button_result_checker
    import bdhd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_psel,
    input  wire logic                  i_penable,
    input  wire logic                  i_pwrite,
    input  wire logic                  i_pready,
    input  wire logic [APB_ADDR_W-1:0] i_paddr,
    input  wire logic [APB_DATA_W-1:0] i_pwdata,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic                  i_pressed,
    input  wire logic [ELAPSED_W-1:0]  i_elapsed_ms,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  wire logic [STATE_W-1:0]    i_button_state,
    input  wire logic                  i_press_event,
    input  wire logic                  i_hold_event,
    output int                         o_mismatches,
    output int                         o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [CFG_W-1:0]       debounce_lim;
    logic [CFG_W-1:0]       hold_lim;
    logic [STATE_W-1:0]     mode;
    logic [TIMER_WIDTH-1:0] press_timer;
    t_result                expected_results[$];
    t_result                got;
    t_result                want;

    function automatic t_result qualify_sample(input logic pressed,
                                               input logic [ELAPSED_W-1:0] ms);
        logic [TIMER_WIDTH:0] sum;
        t_result              r;
        r = '0;
        sum = press_timer + ms;
        press_timer = sum[TIMER_WIDTH] ? '1 : sum[TIMER_WIDTH-1:0];
        if (mode == BTN_ON || mode == BTN_HELD) begin
            if (!pressed) begin
                press_timer = '0;
                mode = BTN_OFF;
            end else if (mode == BTN_ON && press_timer > hold_lim) begin
                mode = BTN_HELD;
                r.hold_event = 1'b1;
            end
        end else if (pressed && press_timer > debounce_lim) begin
            press_timer = '0;
            mode = BTN_ON;
            r.press_event = 1'b1;
        end else begin
            mode = BTN_OFF;
        end
        r.button_state = mode;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            debounce_lim = DEBOUNCE_RESET;
            hold_lim = HOLD_RESET;
            mode = BTN_OFF;
            press_timer = '0;
            expected_results.delete();
            o_outstanding = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[APB_ADDR_W-1:2])
                    REG_DEBOUNCE: debounce_lim = i_pwdata[CFG_W-1:0];
                    REG_HOLD:     hold_lim = i_pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(qualify_sample(i_pressed, i_elapsed_ms));
            end
            if (i_out_valid && i_out_ready) begin
                got.button_state = i_button_state;
                got.press_event = i_press_event;
                got.hold_event = i_hold_event;
                if (expected_results.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= 10) begin
                        $display("unexpected result: state %0d press %0d hold %0d",
                                 got.button_state, got.press_event, got.hold_event);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        o_mismatches++;
                        if (o_mismatches <= 10) begin
                            $display({"result mismatch: expected state %0d press %0d hold %0d,",
                                      " got state %0d press %0d hold %0d"},
                                     want.button_state, want.press_event, want.hold_event,
                                     got.button_state, got.press_event, got.hold_event);
                        end
                    end
                end
            end
            o_outstanding = expected_results.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives button samples and limit writes into the button qualifier: directed
// presses, holds and timer saturation, then random press sequences with noise
// under several limit settings, with random gaps and stalls on both channels
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bdhd_pkg::*;

    localparam int LATENCY     = 2;
    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_pressed;
    logic [ELAPSED_W-1:0]  i_elapsed_ms;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [STATE_W-1:0]    o_button_state;
    logic                  o_press_event;
    logic                  o_hold_event;

    int   mismatches;
    int   outstanding;
    int   sent;
    int   target;
    int   stall_left;
    int   cycles;
    logic no_idle;

    button_debounce_hold_detect DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_pressed      (i_pressed),
        .i_elapsed_ms   (i_elapsed_ms),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_button_state (o_button_state),
        .o_press_event  (o_press_event),
        .o_hold_event   (o_hold_event)
    );

    button_result_checker result_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_pressed      (i_pressed),
        .i_elapsed_ms   (i_elapsed_ms),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_button_state (o_button_state),
        .i_press_event  (o_press_event),
        .i_hold_event   (o_hold_event),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (no_idle || r < 12) begin
            return 0;
        end else if (r < 18) begin
            return $urandom_range(1, 3);
        end else begin
            return $urandom_range(4, 30);
        end
    endfunction

    function automatic logic [ELAPSED_W-1:0] pick_ms();
        if ($urandom_range(0, 4) == 0) begin
            return ELAPSED_W'($urandom_range(0, 255));
        end else begin
            return ELAPSED_W'($urandom_range(0, 60));
        end
    endfunction

    initial begin
        i_out_ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0 && !no_idle) begin
                i_out_ready = 1'b0;
                stall_left--;
            end else begin
                i_out_ready = 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    task automatic send_sample(input logic pressed, input logic [ELAPSED_W-1:0] ms);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_pressed = pressed;
        i_elapsed_ms = ms;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        sent++;
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = APB_DATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic settle();
        i_in_valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (LATENCY + 2) @(negedge i_clk);
    endtask

    task automatic set_limits(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] hold);
        settle();
        write_reg(REG_DEBOUNCE, debounce);
        write_reg(REG_HOLD, hold);
    endtask

    // bounce, steady press, steady release; sometimes plain noise
    task automatic press_sequence();
        int bounce;
        int press_len;
        int release_len;
        bounce = $urandom_range(0, 6);
        press_len = $urandom_range(1, 40);
        release_len = $urandom_range(1, 20);
        no_idle = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 5) == 0) begin
            repeat (10) send_sample(1'($urandom_range(0, 1)),
                                    ELAPSED_W'($urandom_range(0, 255)));
        end else begin
            repeat (bounce) send_sample(1'($urandom_range(0, 1)),
                                        ELAPSED_W'($urandom_range(0, 8)));
            repeat (press_len) send_sample(1'b1, pick_ms());
            repeat (release_len) send_sample(1'b0, pick_ms());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_in_valid = 1'b0;
        i_pressed = 1'b0;
        i_elapsed_ms = '0;
        no_idle = 1'b0;
        sent = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset limits: press, hold, stay held, release, press just past debounce
        send_sample(1'b0, 8'd0);
        send_sample(1'b1, 8'd0);
        send_sample(1'b1, 8'd255);
        repeat (4) send_sample(1'b1, 8'd255);
        send_sample(1'b1, 8'd255);
        send_sample(1'b0, 8'd0);
        send_sample(1'b1, 8'd1);
        send_sample(1'b1, 8'd150);
        send_sample(1'b0, 8'd255);

        // zero limits
        set_limits('0, '0);
        send_sample(1'b1, 8'd0);
        send_sample(1'b1, 8'd1);
        send_sample(1'b1, 8'd0);
        send_sample(1'b1, 8'd1);
        send_sample(1'b0, 8'd0);

        // timer saturation with limits that can never be exceeded
        set_limits('1, '1);
        repeat (260) send_sample(1'($urandom_range(0, 1)), 8'd255);
        set_limits(16'hFFFE, '1);
        send_sample(1'b1, 8'd0);
        repeat (3) send_sample(1'b1, 8'd255);
        send_sample(1'b0, 8'd0);

        for (int phase = 0; phase < 6; phase++) begin
            no_idle = 1'b0;
            case (phase)
                1: set_limits('0, '0);
                3: set_limits('1, '1);
                default: set_limits(CFG_W'($urandom_range(0, 300)),
                                    CFG_W'($urandom_range(0, 1500)));
            endcase
            target = sent + ((phase == 3) ? 10 : 30);
            while (sent < target) press_sequence();
        end

        no_idle = 1'b0;
        settle();
        repeat (LATENCY + 4) @(negedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== button_debounce_hold_detect.f =====
rtl/core/bdhd_pkg.sv
rtl/core/bdhd_cfg.sv
rtl/core/bdhd_qual.sv
rtl/core/button_debounce_hold_detect.sv
sim/button_result_checker.sv
sim/testbench.sv
